[hw/rtl/incremental_pid_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// incremental_pid_controller_core_macros.svh
// Assertion macros shared by the incremental PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IPID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define IPID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/ipid_pkg.sv]
// ----------------------------------------------------------------------------
// ipid_pkg
// Types, register codes, reset values and saturation helper for the
// incremental PID controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int MeasWidth  = 16;
  localparam int CoefWidth  = 16;
  localparam int ErrWidth   = 17;
  localparam int DriveWidth = 24;
  localparam int ProdWidth  = CoefWidth + ErrWidth;   // Q21.12 product
  localparam int SumWidth   = ProdWidth + 2;          // sum of three products
  localparam int FracShift  = 12;                     // Q23.12 -> Q23.0
  localparam int IncWidth   = SumWidth - FracShift;
  localparam int CfgIdxWidth = 2;
  localparam int OutTdataWidth = 48;

  typedef logic signed [MeasWidth-1:0]  meas_t;
  typedef logic signed [CoefWidth-1:0]  coef_t;
  typedef logic signed [ErrWidth-1:0]   err_t;
  typedef logic signed [DriveWidth-1:0] drive_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SETPOINT   = 2'd0,
    REG_COEF_NOW   = 2'd1,
    REG_COEF_PREV  = 2'd2,
    REG_COEF_PREV2 = 2'd3
  } cfg_reg_e;

  // Register values after reset
  localparam meas_t SetpointReset  = 16'sd2048;
  localparam coef_t CoefNowReset   = 16'sd1065;
  localparam coef_t CoefPrevReset  = 16'sd328;
  localparam coef_t CoefPrev2Reset = 16'sd655;

  // Live configuration handed to the datapath
  typedef struct packed {
    meas_t setpoint;
    coef_t coef_now;
    coef_t coef_prev;
    coef_t coef_prev2;
  } cfg_t;

  localparam drive_t DriveMax = 24'sh7FFFFF;
  localparam drive_t DriveMin = -24'sh800000;

  // Clamp a one-bit-wider sum to the drive range
  function automatic drive_t sat_drive(logic signed [DriveWidth:0] value);
    drive_t res;
    if (value[DriveWidth] != value[DriveWidth-1]) begin
      res = value[DriveWidth] ? DriveMin : DriveMax;
    end else begin
      res = value[DriveWidth-1:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/incremental_pid_controller_core.sv]
// ----------------------------------------------------------------------------
// incremental_pid_controller_core
// Velocity-form PID controller: one measurement in, one saturated drive
// and its error out, with setpoint and Q4.12 gains set over a config port.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: measurement[15:0]; tuser: restart
//   m_*      out        tdata: drive[23:0], error_now[40:24], zero pad
//   cfg_*    in         index 0..3, data 16 bits, always ready
//
// One item per clock sustained while the output is not stalled; a result
// passes the input register, then the result register, before it is
// offered on the output.
// The per-item loop is the multiply-accumulate from the state registers
// back into them, with no register in between.
// Reset clears the drive and history and loads the register defaults.
// A stalled output holds the result; the input register keeps taking
// data as long as the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module incremental_pid_controller_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ipid_pkg::MeasWidth-1:0]        s_tdata,   // measurement
  input  logic                                  s_tuser,   // restart
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ipid_pkg::OutTdataWidth-1:0]    m_tdata,   // drive, error_now, pad
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipid_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [ipid_pkg::CoefWidth-1:0]        cfg_data
);
  import ipid_pkg::*;

  `include "incremental_pid_controller_core_macros.svh"

  cfg_t   cfg;
  logic   in_valid;
  meas_t  in_meas;
  logic   in_restart;
  logic   out_free;
  logic   step_en;
  drive_t drive_next;
  err_t   err_now;
  drive_t out_drive;
  err_t   out_err;

  assign cfg_ready = 1'b1;

  ipid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline flow control
  assign out_free = !m_tvalid || m_tready;
  assign step_en  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_meas    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  ipid_step u_step (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .meas       (in_meas),
    .restart    (in_restart),
    .cfg        (cfg),
    .drive_next (drive_next),
    .err_now    (err_now)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_drive <= drive_next;
      out_err   <= err_now;
    end
  end

  assign m_tdata = {{(OutTdataWidth - DriveWidth - ErrWidth){1'b0}}, out_err, out_drive};

  `IPID_ASSERT(a_step_to_out, step_en |=> m_tvalid, "processed item did not reach the output")
  `IPID_ASSERT(a_stall_holds_in, in_valid && !out_free |=> in_valid && $stable(in_meas), "input register lost a waiting item")
  `IPID_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && !in_valid, "pipeline not empty after reset")

endmodule

[hw/rtl/ipid_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ipid_cfg_regs
// Setpoint and coefficient registers, written through the config channel.
// ----------------------------------------------------------------------------
module ipid_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [ipid_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [ipid_pkg::CoefWidth-1:0]    cfg_data,
  output ipid_pkg::cfg_t                    cfg
);
  import ipid_pkg::*;

  // Load the addressed register on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= SetpointReset;
      cfg.coef_now   <= CoefNowReset;
      cfg.coef_prev  <= CoefPrevReset;
      cfg.coef_prev2 <= CoefPrev2Reset;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SETPOINT:   cfg.setpoint   <= cfg_data;
        REG_COEF_NOW:   cfg.coef_now   <= cfg_data;
        REG_COEF_PREV:  cfg.coef_prev  <= cfg_data;
        REG_COEF_PREV2: cfg.coef_prev2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/ipid_step.sv]
// ----------------------------------------------------------------------------
// ipid_step
// Control law datapath: error, three products, rounding, saturating
// accumulate, plus the drive and error history registers.
// ----------------------------------------------------------------------------
module ipid_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_en,
  input  ipid_pkg::meas_t       meas,
  input  logic                  restart,
  input  ipid_pkg::cfg_t        cfg,
  output ipid_pkg::drive_t      drive_next,
  output ipid_pkg::err_t        err_now
);
  import ipid_pkg::*;

  `include "incremental_pid_controller_core_macros.svh"

  drive_t drive_acc;
  err_t   err_last;
  err_t   err_prev2;

  drive_t                       drive_eff;
  err_t                         err_last_eff;
  err_t                         err_prev2_eff;
  logic signed [ProdWidth-1:0]  prod_now;
  logic signed [ProdWidth-1:0]  prod_prev;
  logic signed [ProdWidth-1:0]  prod_prev2;
  logic signed [SumWidth-1:0]   prod_sum;
  logic signed [SumWidth-1:0]   prod_rnd;
  logic signed [IncWidth-1:0]   incr;
  logic signed [DriveWidth:0]   drive_sum;

  // Restart drops the history before this step
  assign drive_eff     = restart ? '0 : drive_acc;
  assign err_last_eff  = restart ? '0 : err_last;
  assign err_prev2_eff = restart ? '0 : err_prev2;

  // Error fits 17 bits without clipping
  assign err_now = ErrWidth'(cfg.setpoint) - ErrWidth'(meas);

  // Three parallel products and their sum
  assign prod_now   = ProdWidth'(cfg.coef_now)   * ProdWidth'(err_now);
  assign prod_prev  = ProdWidth'(cfg.coef_prev)  * ProdWidth'(err_last_eff);
  assign prod_prev2 = ProdWidth'(cfg.coef_prev2) * ProdWidth'(err_prev2_eff);
  assign prod_sum   = SumWidth'(prod_now) + SumWidth'(prod_prev) + SumWidth'(prod_prev2);

  // Round to nearest, ties up, then floor shift down to Q23.0
  assign prod_rnd = prod_sum + SumWidth'(1 << (FracShift - 1));
  assign incr     = prod_rnd[SumWidth-1:FracShift];

  // Accumulate and clamp
  assign drive_sum  = (DriveWidth+1)'(drive_eff) + (DriveWidth+1)'(incr);
  assign drive_next = sat_drive(drive_sum);

  // Advance the state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc <= '0;
      err_last  <= '0;
      err_prev2 <= '0;
    end else if (step_en) begin
      drive_acc <= drive_next;
      err_last  <= err_now;
      err_prev2 <= err_last_eff;
    end
  end

  `IPID_ASSERT(a_state_hold, !step_en |=> $stable(drive_acc) && $stable(err_last) && $stable(err_prev2), "state changed without a step")
  `IPID_ASSERT(a_hist_shift, step_en |=> err_last == $past(err_now), "error history did not shift")
  `IPID_ASSERT(a_restart_clear, step_en && restart |=> err_prev2 == '0, "restart left old history")

endmodule
